### design/rttc_pkg.sv
// ----------------------------------------------------------------------------
// rttc_pkg
// Types and constants shared by the region table block and its parts.
// ----------------------------------------------------------------------------
`default_nettype none
package rttc_pkg;

   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_RESET  = 2'd2;
   localparam logic [1:0] ACT_QUERY  = 2'd3;

   localparam logic [3:0] ST_ADDED     = 4'd0;
   localparam logic [3:0] ST_REMOVED   = 4'd1;
   localparam logic [3:0] ST_RESET     = 4'd2;
   localparam logic [3:0] ST_STALE     = 4'd3;
   localparam logic [3:0] ST_REV_EXH   = 4'd4;
   localparam logic [3:0] ST_RECT_BAD  = 4'd5;
   localparam logic [3:0] ST_FULL      = 4'd6;
   localparam logic [3:0] ST_ID_EXH    = 4'd7;
   localparam logic [3:0] ST_ID_BAD    = 4'd8;
   localparam logic [3:0] ST_NOT_FOUND = 4'd9;
   localparam logic [3:0] ST_GEOM_BAD  = 4'd10;
   localparam logic [3:0] ST_TILE_OK   = 4'd11;
   localparam logic [3:0] ST_TILE_BAD  = 4'd12;

   localparam logic [1:0] CSR_CAPACITY = 2'd0;
   localparam logic [1:0] CSR_WIDTH    = 2'd1;
   localparam logic [1:0] CSR_HEIGHT   = 2'd2;
   localparam logic [1:0] CSR_EPOCH    = 2'd3;

   typedef struct packed {
      logic [1:0]  action;
      logic        kind;
      logic [13:0] rect_x;
      logic [13:0] rect_y;
      logic [14:0] rect_w;
      logic [14:0] rect_h;
      logic [63:0] expected_rev;
      logic [63:0] target_id;
      logic [63:0] new_epoch;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [3:0]  status;
      logic [63:0] revision_out;
      logic [63:0] id_out;
      logic        conflict;
   } rsp_type;

   // one table entry as stored in memory
   typedef struct packed {
      logic [63:0] id;
      logic        kind;
      logic [13:0] left;
      logic [13:0] top;
      logic [14:0] wide;
      logic [14:0] tall;
   } entry_type;

endpackage
`default_nettype wire

### design/rttc_ram.sv
// ----------------------------------------------------------------------------
// rttc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module rttc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(DEPTH)-1:0] wr_addr,
   input  wire [WIDTH-1:0]         wr_data,
   input  wire [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]        rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### design/region_table_tile_conflict.sv
// ----------------------------------------------------------------------------
// region_table_tile_conflict
// Table of pin and exclusion rectangles under a revision counter, with add,
// remove, geometry reset and tile conflict query.
// ----------------------------------------------------------------------------
//  channel  | ports                                 | direction
//  request  | req_start, req_busy, req_item         | in, busy out
//  response | rsp_strobe, rsp_item                  | out, no stall
//  config   | csr_wr_en, csr_index, csr_data        | in
//
// Remove and query sweep the entry memory, one entry per cycle; add, reset
// geometry and every early failure finish without a sweep. Add uses the first
// free slot from a valid-bit vector. Reset is synchronous and clears valid
// bits and counters at once; no clearing pass. The receiver cannot stall:
// the result shows for one cycle.
`default_nettype none
module region_table_tile_conflict #(
   parameter int MAX_REGIONS = 64,
   parameter int TILE_SIZE   = 16,
   parameter int MAX_DIM     = 16384
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_start,
   output logic                req_busy,
   input  wire rttc_pkg::req_type req_item,
   output logic                rsp_strobe,
   output rttc_pkg::rsp_type   rsp_item,
   input  wire                 csr_wr_en,
   input  wire [1:0]           csr_index,
   input  wire [63:0]          csr_data
);
   import rttc_pkg::*;

   localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CW = $clog2(MAX_REGIONS + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;

   logic [1:0]             state_ff, state_in;
   req_type                req_ff, req_in;
   logic [MAX_REGIONS-1:0] valid_ff, valid_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [63:0]            rev_ff, rev_in;
   logic [63:0]            nid_ff, nid_in;
   logic [14:0]            vw_ff, vw_in;
   logic [14:0]            vh_ff, vh_in;
   logic [63:0]            epoch_ff, epoch_in;
   logic [6:0]             cap_ff, cap_in;
   logic [AW:0]            idx_ff, idx_in;       // address issued
   logic                   rdv_ff, rdv_in;       // read data valid
   logic [AW-1:0]          rdi_ff, rdi_in;       // index of read data
   logic                   pin_ff, pin_in;
   logic                   excl_ff, excl_in;
   logic                   hit_ff, hit_in;
   logic [AW-1:0]          hidx_ff, hidx_in;
   logic [15:0]            tl_ff, tr_ff, tt_ff, tb_ff;
   logic [15:0]            tl_in, tr_in, tt_in, tb_in;
   logic                   strobe_ff, strobe_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   entry_type              wr_data, rd_data;

   rttc_ram #(.WIDTH($bits(entry_type)), .DEPTH(MAX_REGIONS)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(idx_ff[AW-1:0]),
      .rd_data(rd_data)
   );

   // combinational helpers
   logic [15:0]   ax_r, ay_b, cols, rows, lx, ty, rx, by;
   logic [CW-1:0] limit;
   logic          free_found;
   logic [AW-1:0] free_idx;
   logic [16:0]   e_r, e_b;

   always_comb begin
      ax_r = {2'b0, req_ff.rect_x} + {1'b0, req_ff.rect_w};
      ay_b = {2'b0, req_ff.rect_y} + {1'b0, req_ff.rect_h};
      cols = 16'(({1'b0, vw_ff} + 16'(TILE_SIZE - 1)) / TILE_SIZE);
      rows = 16'(({1'b0, vh_ff} + 16'(TILE_SIZE - 1)) / TILE_SIZE);
      lx   = 16'(req_ff.rect_x * TILE_SIZE);
      ty   = 16'(req_ff.rect_y * TILE_SIZE);
      rx   = (17'(lx) + 17'(TILE_SIZE) < 17'(vw_ff)) ? 16'(lx + 16'(TILE_SIZE))
                                                     : {1'b0, vw_ff};
      by   = (17'(ty) + 17'(TILE_SIZE) < 17'(vh_ff)) ? 16'(ty + 16'(TILE_SIZE))
                                                     : {1'b0, vh_ff};
      if (32'(cap_ff) < 32'(MAX_REGIONS)) begin
         limit = CW'(cap_ff);
      end else begin
         limit = CW'(MAX_REGIONS);
      end
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = MAX_REGIONS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = AW'(i);
         end
      end
      e_r = 17'(rd_data.left) + 17'(rd_data.wide);
      e_b = 17'(rd_data.top) + 17'(rd_data.tall);
   end

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      valid_in  = valid_ff;
      count_in  = count_ff;
      rev_in    = rev_ff;
      nid_in    = nid_ff;
      vw_in     = vw_ff;
      vh_in     = vh_ff;
      epoch_in  = epoch_ff;
      cap_in    = cap_ff;
      idx_in    = idx_ff;
      rdv_in    = 1'b0;
      rdi_in    = idx_ff[AW-1:0];
      pin_in    = pin_ff;
      excl_in   = excl_ff;
      hit_in    = hit_ff;
      hidx_in   = hidx_ff;
      tl_in     = tl_ff;
      tr_in     = tr_ff;
      tt_in     = tt_ff;
      tb_in     = tb_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      wr_en     = 1'b0;
      wr_addr   = free_idx;
      wr_data   = '{id: nid_ff, kind: req_ff.kind, left: req_ff.rect_x,
                    top: req_ff.rect_y, wide: req_ff.rect_w, tall: req_ff.rect_h};

      if (csr_wr_en) begin
         case (csr_index)
            CSR_CAPACITY: cap_in   = csr_data[6:0];
            CSR_WIDTH:    vw_in    = csr_data[14:0];
            CSR_HEIGHT:   vh_in    = csr_data[14:0];
            CSR_EPOCH:    epoch_in = csr_data;
            default:      cap_in   = cap_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_start) begin
               req_in   = req_item;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rsp_in    = '{ok: 1'b0, status: ST_STALE, revision_out: rev_ff,
                          id_out: 64'd0, conflict: 1'b0};
            strobe_in = 1'b1;
            state_in  = S_IDLE;
            if (req_ff.action == ACT_QUERY) begin
               if (16'(req_ff.rect_x) >= cols || 16'(req_ff.rect_y) >= rows) begin
                  rsp_in.status = ST_TILE_BAD;
               end else begin
                  tl_in = lx; tt_in = ty; tr_in = rx; tb_in = by;
                  pin_in = 1'b0; excl_in = 1'b0;
                  idx_in = '0; strobe_in = 1'b0; state_in = S_SCAN;
               end
            end else if (req_ff.expected_rev != rev_ff) begin
               rsp_in.status = ST_STALE;
            end else if (rev_ff == '1) begin
               rsp_in.status = ST_REV_EXH;
            end else if (req_ff.action == ACT_ADD) begin
               if (req_ff.rect_w == '0 || req_ff.rect_h == '0 ||
                   ax_r > 16'(vw_ff) || ay_b > 16'(vh_ff)) begin
                  rsp_in.status = ST_RECT_BAD;
               end else if (count_ff >= limit || !free_found) begin
                  rsp_in.status = ST_FULL;
               end else if (nid_ff == '0) begin
                  rsp_in.status = ST_ID_EXH;
               end else begin
                  wr_en              = 1'b1;
                  valid_in[free_idx] = 1'b1;
                  count_in           = count_ff + 1'b1;
                  nid_in             = nid_ff + 64'd1;
                  rev_in             = rev_ff + 64'd1;
                  rsp_in = '{ok: 1'b1, status: ST_ADDED, revision_out: rev_ff + 64'd1,
                             id_out: nid_ff, conflict: 1'b0};
               end
            end else if (req_ff.action == ACT_REMOVE) begin
               if (req_ff.target_id == '0) begin
                  rsp_in.status = ST_ID_BAD;
               end else begin
                  hit_in = 1'b0; idx_in = '0; strobe_in = 1'b0; state_in = S_SCAN;
               end
            end else begin
               if (req_ff.rect_w == '0 || req_ff.rect_h == '0 ||
                   32'(req_ff.rect_w) > 32'(MAX_DIM) ||
                   32'(req_ff.rect_h) > 32'(MAX_DIM) ||
                   req_ff.new_epoch == '0 || req_ff.new_epoch <= epoch_ff) begin
                  rsp_in.status = ST_GEOM_BAD;
               end else begin
                  vw_in    = req_ff.rect_w;
                  vh_in    = req_ff.rect_h;
                  epoch_in = req_ff.new_epoch;
                  valid_in = '0;
                  count_in = '0;
                  rev_in   = rev_ff + 64'd1;
                  rsp_in   = '{ok: 1'b1, status: ST_RESET, revision_out: rev_ff + 64'd1,
                               id_out: 64'd0, conflict: 1'b0};
               end
            end
         end
         S_SCAN: begin
            // issue reads until all addresses are out, then drain last data
            if (32'(idx_ff) < MAX_REGIONS) begin
               rdv_in = 1'b1;
               idx_in = idx_ff + 1'b1;
            end
            if (rdv_ff && valid_ff[rdi_ff]) begin
               if (req_ff.action == ACT_QUERY) begin
                  if (16'(rd_data.left) < tr_ff && e_r > 17'(tl_ff) &&
                      16'(rd_data.top) < tb_ff && e_b > 17'(tt_ff)) begin
                     if (rd_data.kind) excl_in = 1'b1;
                     else pin_in = 1'b1;
                  end
               end else if (!hit_ff && rd_data.id == req_ff.target_id) begin
                  hit_in  = 1'b1;
                  hidx_in = rdi_ff;
               end
            end
            if (32'(idx_ff) == MAX_REGIONS && !rdv_ff) begin
               strobe_in = 1'b1;
               state_in  = S_IDLE;
               if (req_ff.action == ACT_QUERY) begin
                  rsp_in = '{ok: 1'b1, status: ST_TILE_OK, revision_out: rev_ff,
                             id_out: 64'd0, conflict: pin_ff & excl_ff};
               end else if (hit_ff) begin
                  valid_in[hidx_ff] = 1'b0;
                  if (count_ff != '0) count_in = count_ff - 1'b1;
                  rev_in = rev_ff + 64'd1;
                  rsp_in = '{ok: 1'b1, status: ST_REMOVED, revision_out: rev_ff + 64'd1,
                             id_out: req_ff.target_id, conflict: 1'b0};
               end else begin
                  rsp_in = '{ok: 1'b0, status: ST_NOT_FOUND, revision_out: rev_ff,
                             id_out: 64'd0, conflict: 1'b0};
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         valid_ff  <= '0;
         count_ff  <= '0;
         rev_ff    <= '0;
         nid_ff    <= 64'd1;
         vw_ff     <= 15'd1920;
         vh_ff     <= 15'd1080;
         epoch_ff  <= 64'd1;
         cap_ff    <= 7'd64;
         idx_ff    <= '0;
         rdv_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         count_ff  <= count_in;
         rev_ff    <= rev_in;
         nid_ff    <= nid_in;
         vw_ff     <= vw_in;
         vh_ff     <= vh_in;
         epoch_ff  <= epoch_in;
         cap_ff    <= cap_in;
         idx_ff    <= idx_in;
         rdv_ff    <= rdv_in;
         strobe_ff <= strobe_in;
      end
      req_ff  <= req_in;
      rdi_ff  <= rdi_in;
      pin_ff  <= pin_in;
      excl_ff <= excl_in;
      hit_ff  <= hit_in;
      hidx_ff <= hidx_in;
      tl_ff   <= tl_in;
      tr_ff   <= tr_in;
      tt_ff   <= tt_in;
      tb_ff   <= tb_in;
      rsp_ff  <= rsp_in;
   end

   assign req_busy   = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;
endmodule
`default_nettype wire

### design/rttc_checker.sv
// ----------------------------------------------------------------------------
// rttc_checker
// Port-level checks on the region table block.
// ----------------------------------------------------------------------------
`default_nettype none
module rttc_checker (
   input wire                clock,
   input wire                reset,
   input wire                req_start,
   input wire                req_busy,
   input wire                rsp_strobe,
   input wire rttc_pkg::rsp_type rsp_item
);
   import rttc_pkg::*;

   // accepted item makes the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_start && !req_busy |=> req_busy) else $error("accept not busy");

   // a result only comes right after busy
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(req_busy)) else $error("stray result");

   // one result per item: busy ends with the strobe
   a_done: assert property (@(posedge clock) disable iff (reset)
      $fell(req_busy) |-> rsp_strobe) else $error("busy fell without result");

   // ok agrees with success codes
   a_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_item.ok == (rsp_item.status == ST_ADDED ||
         rsp_item.status == ST_REMOVED || rsp_item.status == ST_RESET ||
         rsp_item.status == ST_TILE_OK)) else $error("ok mismatch");
endmodule

bind region_table_tile_conflict rttc_checker u_rttc_checker (
   .clock(clock), .reset(reset), .req_start(req_start), .req_busy(req_busy),
   .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
);
`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives region table actions, predicts each response and compares it field
// by field; random bursts mix add, remove, geometry reset and tile queries.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
   import rttc_pkg::*;

   localparam int NREG = 64;
   localparam int TSZ  = 16;
   localparam int MAXD = 16384;
   localparam longint unsigned CYCLE_LIMIT = 400000;

   logic clock, reset;
   logic req_start;
   logic req_busy;
   req_type req_item;
   logic rsp_strobe;
   rsp_type rsp_item;
   logic csr_wr_en;
   logic [1:0] csr_index;
   logic [63:0] csr_data;

   region_table_tile_conflict u_top (
      .clock(clock), .reset(reset),
      .req_start(req_start), .req_busy(req_busy), .req_item(req_item),
      .rsp_strobe(rsp_strobe), .rsp_item(rsp_item),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // shadow copy of the table
   bit          tbl_valid [NREG];
   logic [63:0] tbl_id    [NREG];
   bit          tbl_kind  [NREG];
   int unsigned tbl_left  [NREG], tbl_top [NREG], tbl_wide [NREG], tbl_tall [NREG];
   int unsigned tbl_count;
   logic [63:0] cur_rev, next_id, view_epoch;
   int unsigned view_w, view_h, cap_reg;

   rsp_type pending_rsp[$];
   int unsigned error_count;
   longint unsigned cycle_count;
   bit timed_out;

   function automatic rsp_type make_rsp(bit ok, logic [3:0] st, logic [63:0] id, bit cf);
      rsp_type r;
      r.ok = ok; r.status = st; r.revision_out = cur_rev; r.id_out = id; r.conflict = cf;
      return r;
   endfunction

   function automatic void clear_table();
      for (int i = 0; i < NREG; i++) tbl_valid[i] = 0;
      tbl_count = 0;
   endfunction

   function automatic rsp_type apply_action(req_type q);
      int unsigned x, y, w, h, lim, cols, rows, l, t, r, b;
      int slot;
      bit pin, excl;
      x = 32'(q.rect_x); y = 32'(q.rect_y); w = 32'(q.rect_w); h = 32'(q.rect_h);
      if (q.action == ACT_QUERY) begin
         cols = (view_w + TSZ - 1) / TSZ;
         rows = (view_h + TSZ - 1) / TSZ;
         if (x >= cols || y >= rows) return make_rsp(0, ST_TILE_BAD, 0, 0);
         l = x * TSZ; t = y * TSZ;
         r = (l + TSZ < view_w) ? l + TSZ : view_w;
         b = (t + TSZ < view_h) ? t + TSZ : view_h;
         pin = 0; excl = 0;
         for (int i = 0; i < NREG; i++)
            if (tbl_valid[i] && tbl_left[i] < r && tbl_left[i] + tbl_wide[i] > l &&
                tbl_top[i] < b && tbl_top[i] + tbl_tall[i] > t) begin
               if (tbl_kind[i]) excl = 1; else pin = 1;
            end
         return make_rsp(1, ST_TILE_OK, 0, pin && excl);
      end
      if (q.expected_rev != cur_rev) return make_rsp(0, ST_STALE, 0, 0);
      if (cur_rev == '1) return make_rsp(0, ST_REV_EXH, 0, 0);
      case (q.action)
         ACT_ADD: begin
            lim = (cap_reg < NREG) ? cap_reg : NREG;
            if (w == 0 || h == 0 || x + w > view_w || y + h > view_h)
               return make_rsp(0, ST_RECT_BAD, 0, 0);
            if (tbl_count >= lim) return make_rsp(0, ST_FULL, 0, 0);
            if (next_id == 0) return make_rsp(0, ST_ID_EXH, 0, 0);
            slot = -1;
            for (int i = 0; i < NREG; i++)
               if (slot < 0 && !tbl_valid[i]) slot = i;
            if (slot < 0) return make_rsp(0, ST_FULL, 0, 0);
            tbl_valid[slot] = 1; tbl_id[slot] = next_id; tbl_kind[slot] = q.kind;
            tbl_left[slot] = x; tbl_top[slot] = y; tbl_wide[slot] = w; tbl_tall[slot] = h;
            tbl_count++; next_id++; cur_rev++;
            return make_rsp(1, ST_ADDED, tbl_id[slot], 0);
         end
         ACT_REMOVE: begin
            if (q.target_id == 0) return make_rsp(0, ST_ID_BAD, 0, 0);
            for (int i = 0; i < NREG; i++)
               if (tbl_valid[i] && tbl_id[i] == q.target_id) begin
                  tbl_valid[i] = 0;
                  if (tbl_count > 0) tbl_count--;
                  cur_rev++;
                  return make_rsp(1, ST_REMOVED, q.target_id, 0);
               end
            return make_rsp(0, ST_NOT_FOUND, 0, 0);
         end
         default: begin
            if (w == 0 || h == 0 || w > MAXD || h > MAXD || q.new_epoch == 0 ||
                q.new_epoch <= view_epoch)
               return make_rsp(0, ST_GEOM_BAD, 0, 0);
            view_w = w; view_h = h; view_epoch = q.new_epoch;
            clear_table();
            cur_rev++;
            return make_rsp(1, ST_RESET, 0, 0);
         end
      endcase
   endfunction

   // response checker
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response %p", $time, rsp_item);
            error_count++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (exp_rsp.ok !== rsp_item.ok) begin
               $display("%0t: ok expected %0d actual %0d", $time, exp_rsp.ok, rsp_item.ok);
               error_count++;
            end
            if (exp_rsp.status !== rsp_item.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        exp_rsp.status, rsp_item.status);
               error_count++;
            end
            if (exp_rsp.revision_out !== rsp_item.revision_out) begin
               $display("%0t: revision expected %0h actual %0h", $time,
                        exp_rsp.revision_out, rsp_item.revision_out);
               error_count++;
            end
            if (exp_rsp.id_out !== rsp_item.id_out) begin
               $display("%0t: id expected %0h actual %0h", $time,
                        exp_rsp.id_out, rsp_item.id_out);
               error_count++;
            end
            if (exp_rsp.conflict !== rsp_item.conflict) begin
               $display("%0t: conflict expected %0d actual %0d", $time,
                        exp_rsp.conflict, rsp_item.conflict);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) timed_out = 1;
   end

   // hands one item to the block and queues its prediction
   task automatic issue(req_type q, bit check_fixed = 0, rsp_type fixed = '0);
      rsp_type pr;
      req_start <= 1;
      req_item  <= q;
      @(posedge clock);
      while (req_busy) @(posedge clock);
      pr = apply_action(q);
      if (check_fixed && pr !== fixed) begin
         $display("%0t: table row expected %p actual %p", $time, fixed, pr);
         error_count++;
      end
      pending_rsp.insert(pending_rsp.size(), pr);
   endtask

   task automatic idle_cycles(int n);
      req_start <= 0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      req_start <= 0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (NREG + 8) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [63:0] val);
      csr_wr_en <= 1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      csr_wr_en <= 0;
      case (idx)
         CSR_CAPACITY: cap_reg = 32'(val[6:0]);
         CSR_WIDTH:    view_w = 32'(val[14:0]);
         CSR_HEIGHT:   view_h = 32'(val[14:0]);
         default:      view_epoch = val;
      endcase
   endtask

   function automatic req_type mk(logic [1:0] a, bit k, int unsigned x, int unsigned y,
                                  int unsigned w, int unsigned h, logic [63:0] rev,
                                  logic [63:0] id, logic [63:0] ep);
      req_type q;
      q.action = a; q.kind = k; q.rect_x = 14'(x); q.rect_y = 14'(y);
      q.rect_w = 15'(w); q.rect_h = 15'(h);
      q.expected_rev = rev; q.target_id = id; q.new_epoch = ep;
      return q;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // random item, mostly well-formed against current state
   function automatic req_type rand_item();
      req_type q;
      int unsigned sel, w, h;
      q = $bits(req_type)'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                            $urandom(), $urandom(), $urandom()});
      sel = $urandom_range(0, 99);
      q.expected_rev = ($urandom_range(0, 9) == 0) ? rand64() : cur_rev;
      if (sel < 40) begin
         q.action = ACT_ADD;
         w = (view_w > 0) ? view_w : 1;
         h = (view_h > 0) ? view_h : 1;
         q.rect_w = 15'($urandom_range(1, (w < 400) ? w : 400));
         q.rect_h = 15'($urandom_range(1, (h < 400) ? h : 400));
         q.rect_x = (w > 32'(q.rect_w)) ? 14'($urandom_range(0, w - 32'(q.rect_w))) : '0;
         q.rect_y = (h > 32'(q.rect_h)) ? 14'($urandom_range(0, h - 32'(q.rect_h))) : '0;
         if ($urandom_range(0, 9) == 0) q.rect_w = 15'($urandom_range(0, 16384));
      end else if (sel < 60) begin
         q.action = ACT_REMOVE;
         if ($urandom_range(0, 4) != 0 && next_id > 1) begin
            if (next_id > 200)
               q.target_id = next_id - 64'($urandom_range(0, 199));
            else
               q.target_id = 64'($urandom_range(1, 32'(next_id - 64'd1)));
         end
      end else if (sel < 65) begin
         q.action = ACT_RESET;
         q.rect_w = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(0, 32767))
                                                : 15'($urandom_range(1, 2048));
         q.rect_h = 15'($urandom_range(1, 2048));
         q.new_epoch = ($urandom_range(0, 3) == 0) ? rand64()
                                                   : view_epoch + 64'($urandom_range(0, 5));
      end else begin
         q.action = ACT_QUERY;
         q.rect_x = ($urandom_range(0, 3) == 0) ? 14'($urandom_range(0, 16383))
                                                : 14'($urandom_range(0, view_w / TSZ + 1));
         q.rect_y = 14'($urandom_range(0, view_h / TSZ + 1));
      end
      return q;
   endfunction

   // directed rows
   typedef struct {
      req_type q;
      bit      has_fixed;
      rsp_type fixed;
   } stim_row;

   initial begin
      stim_row rows[$];
      stim_row sr;
      int burst;
      rsp_type rz;
      reset = 1; req_start = 0; req_item = '0;
      csr_wr_en = 0; csr_index = CSR_CAPACITY; csr_data = '0;
      error_count = 0; cycle_count = 0; timed_out = 0;
      clear_table();
      for (int i = 0; i < NREG; i++) tbl_id[i] = 0;
      cur_rev = 0; next_id = 1; view_epoch = 1; view_w = 1920; view_h = 1080; cap_reg = 64;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // phase 1: directed table at reset configuration
      rz = '0;
      sr.has_fixed = 1;
      sr.q = mk(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0);
      sr.fixed = rz; sr.fixed.ok = 1; sr.fixed.status = ST_TILE_OK;
      rows.insert(rows.size(), sr);
      sr.q = mk(ACT_QUERY, 0, 120, 0, 0, 0, 0, 0, 0);
      sr.fixed = rz; sr.fixed.status = ST_TILE_BAD; rows.insert(rows.size(), sr);
      sr.q = mk(ACT_QUERY, 0, 16383, 16383, 0, 0, 0, 0, 0);
      sr.fixed = rz; sr.fixed.status = ST_TILE_BAD; rows.insert(rows.size(), sr);
      sr.q = mk(ACT_ADD, 0, 0, 0, 10, 10, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
      sr.fixed = rz; sr.fixed.status = ST_STALE; rows.insert(rows.size(), sr);
      sr.q = mk(ACT_ADD, 0, 0, 0, 0, 10, 0, 0, 0);
      sr.fixed = rz; sr.fixed.status = ST_RECT_BAD; rows.insert(rows.size(), sr);
      sr.q = mk(ACT_ADD, 0, 1911, 0, 10, 10, 0, 0, 0);
      sr.fixed = rz; sr.fixed.status = ST_RECT_BAD; rows.insert(rows.size(), sr);
      sr.q = mk(ACT_ADD, 0, 0, 0, 16384, 16384, 0, 0, 0);
      sr.fixed = rz; sr.fixed.status = ST_RECT_BAD; rows.insert(rows.size(), sr);
      sr.q = mk(ACT_ADD, 0, 0, 0, 1920, 1080, 0, 0, 0);
      sr.fixed = rz; sr.fixed.ok = 1; sr.fixed.status = ST_ADDED; sr.fixed.revision_out = 1;
      sr.fixed.id_out = 1; rows.insert(rows.size(), sr);
      sr.has_fixed = 0;
      rows.insert(rows.size(), '{mk(ACT_ADD, 1, 16, 16, 20, 20, 1, 0, 0), 0, rz});
      rows.insert(rows.size(), '{mk(ACT_QUERY, 1, 1, 1, 0, 0, 64'h5555, 0, 0), 0, rz});
      rows.insert(rows.size(), '{mk(ACT_QUERY, 0, 3, 3, 0, 0, 0, 0, 0), 0, rz});
      rows.insert(rows.size(), '{mk(ACT_QUERY, 0, 119, 67, 0, 0, 0, 0, 0), 0, rz});
      rows.insert(rows.size(), '{mk(ACT_REMOVE, 0, 0, 0, 0, 0, 2, 0, 0), 0, rz});
      rows.insert(rows.size(), '{mk(ACT_REMOVE, 0, 0, 0, 0, 0, 2, 99, 0), 0, rz});
      rows.insert(rows.size(), '{mk(ACT_REMOVE, 0, 0, 0, 0, 0, 2, 2, 0), 0, rz});
      rows.insert(rows.size(), '{mk(ACT_REMOVE, 0, 0, 0, 0, 0, 3, 2, 0), 0, rz});
      rows.insert(rows.size(), '{mk(ACT_RESET, 0, 0, 0, 0, 100, 3, 0, 5), 0, rz});
      rows.insert(rows.size(), '{mk(ACT_RESET, 0, 0, 0, 16385, 100, 3, 0, 5), 0, rz});
      rows.insert(rows.size(), '{mk(ACT_RESET, 0, 0, 0, 100, 100, 3, 0, 1), 0, rz});
      rows.insert(rows.size(), '{mk(ACT_RESET, 0, 0, 0, 100, 100, 3, 0, 0), 0, rz});
      rows.insert(rows.size(),
                  '{mk(ACT_RESET, 0, 0, 0, 16384, 16384, 3, 0, 64'hFFFF_FFFF_FFFF_FFFE), 0, rz});
      rows.insert(rows.size(), '{mk(ACT_ADD, 1, 16383, 16383, 1, 1, 4, 0, 0), 0, rz});
      rows.insert(rows.size(), '{mk(ACT_QUERY, 0, 1023, 1023, 0, 0, 0, 0, 0), 0, rz});
      rows.insert(rows.size(), '{mk(ACT_QUERY, 0, 1024, 0, 0, 0, 0, 0, 0), 0, rz});
      foreach (rows[i]) issue(rows[i].q, rows[i].has_fixed, rows[i].fixed);
      drain();

      // phase 2..6: several configurations, with random bursts
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin write_csr(CSR_CAPACITY, 3); write_csr(CSR_WIDTH, 64);
                     write_csr(CSR_HEIGHT, 48); write_csr(CSR_EPOCH, 7); end
            1: begin write_csr(CSR_CAPACITY, 1); write_csr(CSR_WIDTH, 16384);
                     write_csr(CSR_HEIGHT, 16384); end
            2: begin write_csr(CSR_CAPACITY, 0); write_csr(CSR_WIDTH, 1);
                     write_csr(CSR_HEIGHT, 1); write_csr(CSR_EPOCH, 64'hFFFF_FFFF_FFFF_FFFF); end
            3: begin write_csr(CSR_CAPACITY, 127); write_csr(CSR_WIDTH, 0);
                     write_csr(CSR_HEIGHT, 32767); write_csr(CSR_EPOCH, 2); end
            default: begin write_csr(CSR_CAPACITY, 64); write_csr(CSR_WIDTH, 320);
                     write_csr(CSR_HEIGHT, 200); write_csr(CSR_EPOCH, 1); end
         endcase
         for (int n = 0; n < ((ph == 4) ? 200 : 100); ) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst; k++, n++) issue(rand_item());
            case ($urandom_range(0, 3))
               0: ;
               1: idle_cycles($urandom_range(1, 3));
               2: idle_cycles($urandom_range(4, 80));
               default: begin
                  req_start <= 0;
                  @(posedge clock);
                  while (pending_rsp.size() != 0) @(posedge clock);
               end
            endcase
         end
         drain();
      end
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      wait (timed_out);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire
